[rtl/cmp_pkg.sv]
// cmp_pkg: shared types and codes for the coap message parser
// holds the input item, result item and parse state structs plus phase, event and error codes
// no dependencies
`default_nettype none

package cmp_pkg;

    localparam int unsigned PhaseW = 3;

    localparam logic [PhaseW-1:0] PH_HEADER    = 3'd0;
    localparam logic [PhaseW-1:0] PH_TOKEN     = 3'd1;
    localparam logic [PhaseW-1:0] PH_OPTHDR    = 3'd2;
    localparam logic [PhaseW-1:0] PH_DELTA_EXT = 3'd3;
    localparam logic [PhaseW-1:0] PH_LEN_EXT   = 3'd4;
    localparam logic [PhaseW-1:0] PH_VALUE     = 3'd5;
    localparam logic [PhaseW-1:0] PH_PAYLOAD   = 3'd6;
    localparam logic [PhaseW-1:0] PH_DROP      = 3'd7;

    localparam logic [2:0] EV_CONSUMED  = 3'd0;
    localparam logic [2:0] EV_HEADER    = 3'd1;
    localparam logic [2:0] EV_TOKEN     = 3'd2;
    localparam logic [2:0] EV_OPT_VALUE = 3'd3;
    localparam logic [2:0] EV_PAYLOAD   = 3'd4;
    localparam logic [2:0] EV_MARKER    = 3'd5;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_SHORT_HEADER = 3'd1;
    localparam logic [2:0] ERR_TOKEN_LONG   = 3'd2;
    localparam logic [2:0] ERR_TOKEN_TRUNC  = 3'd3;
    localparam logic [2:0] ERR_RESERVED     = 3'd4;
    localparam logic [2:0] ERR_EXT_TRUNC    = 3'd5;
    localparam logic [2:0] ERR_VALUE_TRUNC  = 3'd6;

    localparam logic [3:0] MAX_TOKEN_RESET = 4'd12;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } cmp_in_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  byte_out;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  token_length;
        logic [7:0]  code;
        logic [15:0] message_id;
        logic        option_start;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic        message_done;
        logic [2:0]  error_code;
    } cmp_out_t;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic [1:0]        hcount;
        logic [7:0]        hdr_byte0;
        logic [7:0]        hdr_code;
        logic [7:0]        id_high;
        logic [7:0]        id_low;
        logic [3:0]        token_left;
        logic [15:0]       running_option;
        logic [15:0]       delta_accum;
        logic [15:0]       length_accum;
        logic [7:0]        nibble_pending;
        logic [15:0]       value_left;
        logic [2:0]        error_latched;
    } cmp_state_t;

endpackage

`default_nettype wire

[rtl/coap_message_parser.sv]
// coap_message_parser: top level, parse state, token limit register and result register
// depends on cmp_pkg and cmp_step
`default_nettype none

// Streaming parser for one datagram a byte at a time (last_byte marks the end): it decodes
// the 4-byte header, checks the token length against max_token_length (reset 12), passes
// token, option value and payload bytes, gives option numbers and lengths as option headers
// complete. Each accepted byte gives exactly one result item, registered and offered on the
// cycle after acceptance. One byte per clock is sustained: the parse state is updated once
// per byte by a single decode stage, and a new byte is taken while the previous result is
// being taken by the sink. After an error, bytes are consumed with the error code until the
// last byte; the last byte always returns the parser to the header phase.

module coap_message_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output var  logic              s_ready,
    input  var  cmp_pkg::cmp_in_t  s_data,
    output var  logic              m_valid,
    input  wire logic              m_ready,
    output var  cmp_pkg::cmp_out_t m_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [3:0]        cfg_wr_data
);

    cmp_pkg::cmp_state_t state_reg;
    cmp_pkg::cmp_state_t state_next;
    cmp_pkg::cmp_out_t   res_reg;
    cmp_pkg::cmp_out_t   res_next;
    logic                m_valid_reg;
    logic [3:0]          max_tok_reg;
    logic                accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

    cmp_step u_step (
        .st               (state_reg),
        .in_item          (s_data),
        .max_token_length (max_tok_reg),
        .nx               (state_next),
        .res              (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // all zero is the header phase
            state_reg       <= '0;
            m_valid_reg     <= 1'b0;
            max_tok_reg     <= cmp_pkg::MAX_TOKEN_RESET;
        end else begin
            if (cfg_wr_en) max_tok_reg <= cfg_wr_data;
            if (accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) res_reg <= res_next;
    end

endmodule

`default_nettype wire

[rtl/cmp_step.sv]
// cmp_step: per-byte decode of the parser, next parse state and result item
// combinational; uses cmp_pkg types and codes
`default_nettype none

module cmp_step (
    input  var cmp_pkg::cmp_state_t st,
    input  var cmp_pkg::cmp_in_t    in_item,
    input  wire logic [3:0]         max_token_length,
    output var cmp_pkg::cmp_state_t nx,
    output var cmp_pkg::cmp_out_t   res
);

    localparam logic [15:0] ExtBase1 = 16'd13;
    localparam logic [15:0] ExtBase2 = 16'd269;
    localparam logic [3:0]  NibExt1  = 4'd13;
    localparam logic [3:0]  NibExt2  = 4'd14;
    localparam logic [3:0]  NibRsvd  = 4'd15;
    localparam logic [7:0]  Marker   = 8'hFF;

    function automatic logic [15:0] ext_base(input logic [3:0] nib);
        return (nib == NibExt1) ? ExtBase1 : ExtBase2;
    endfunction

    logic [7:0]  b;
    logic        last;
    logic [2:0]  ev;
    logic [7:0]  bo;
    logic [2:0]  fail;
    logic        ostart;
    logic [15:0] olen;
    logic        run_len;
    logic        run_fin;
    logic [3:0]  tkl;
    logic [3:0]  dnib;
    logic [3:0]  lnib;
    logic [15:0] ext_shift;
    logic        hdr_ok;
    cmp_pkg::cmp_state_t work;

    assign b    = in_item.data_byte;
    assign last = in_item.last_byte;

    always_comb begin
        work      = st;
        ev        = cmp_pkg::EV_CONSUMED;
        bo        = 8'd0;
        fail      = cmp_pkg::ERR_NONE;
        ostart    = 1'b0;
        olen      = 16'd0;
        run_len   = 1'b0;
        run_fin   = 1'b0;
        tkl       = st.hdr_byte0[3:0];
        dnib      = b[7:4];
        lnib      = 4'd0;
        ext_shift = 16'd0;

        unique case (st.phase)
            cmp_pkg::PH_HEADER: begin
                unique case (st.hcount)
                    2'd0: work.hdr_byte0 = b;
                    2'd1: work.hdr_code  = b;
                    2'd2: work.id_high   = b;
                    default: work.id_low = b;
                endcase
                if (st.hcount != 2'd3) begin
                    work.hcount = st.hcount + 2'd1;
                    if (last) fail = cmp_pkg::ERR_SHORT_HEADER;
                end else begin
                    work.hcount = 2'd0;
                    ev = cmp_pkg::EV_HEADER;
                    if (tkl > max_token_length) begin
                        work.phase = cmp_pkg::PH_DROP;
                        fail = cmp_pkg::ERR_TOKEN_LONG;
                    end else if (tkl != 4'd0) begin
                        work.token_left = tkl;
                        work.phase = cmp_pkg::PH_TOKEN;
                        if (last) fail = cmp_pkg::ERR_TOKEN_TRUNC;
                    end else begin
                        work.phase = cmp_pkg::PH_OPTHDR;
                    end
                end
            end
            cmp_pkg::PH_TOKEN: begin
                ev = cmp_pkg::EV_TOKEN;
                bo = b;
                work.token_left = st.token_left - 4'd1;
                if (work.token_left == 4'd0) begin
                    work.phase = cmp_pkg::PH_OPTHDR;
                end else if (last) begin
                    fail = cmp_pkg::ERR_TOKEN_TRUNC;
                end
            end
            cmp_pkg::PH_OPTHDR: begin
                if (b == Marker) begin
                    ev = cmp_pkg::EV_MARKER;
                    work.phase = cmp_pkg::PH_PAYLOAD;
                end else begin
                    work.nibble_pending = b;
                    work.delta_accum = 16'd0;
                    work.length_accum = 16'd0;
                    if (dnib == NibRsvd) begin
                        fail = cmp_pkg::ERR_RESERVED;
                    end else if (dnib >= NibExt1) begin
                        work.phase = cmp_pkg::PH_DELTA_EXT;
                        work.hcount = {1'b0, dnib == NibExt2};
                        if (last) fail = cmp_pkg::ERR_EXT_TRUNC;
                    end else begin
                        work.delta_accum = {12'd0, dnib};
                        run_len = 1'b1;
                    end
                end
            end
            cmp_pkg::PH_DELTA_EXT: begin
                ext_shift = {st.delta_accum[7:0], b};
                work.delta_accum = ext_shift;
                if (st.hcount != 2'd0) begin
                    work.hcount = 2'd0;
                    if (last) fail = cmp_pkg::ERR_EXT_TRUNC;
                end else begin
                    work.delta_accum = ext_shift + ext_base(st.nibble_pending[7:4]);
                    run_len = 1'b1;
                end
            end
            cmp_pkg::PH_LEN_EXT: begin
                ext_shift = {st.length_accum[7:0], b};
                work.length_accum = ext_shift;
                if (st.hcount != 2'd0) begin
                    work.hcount = 2'd0;
                    if (last) fail = cmp_pkg::ERR_EXT_TRUNC;
                end else begin
                    work.length_accum = ext_shift + ext_base(st.nibble_pending[3:0]);
                    run_fin = 1'b1;
                end
            end
            cmp_pkg::PH_VALUE: begin
                ev = cmp_pkg::EV_OPT_VALUE;
                bo = b;
                work.value_left = st.value_left - 16'd1;
                if (work.value_left == 16'd0) begin
                    work.phase = cmp_pkg::PH_OPTHDR;
                end else if (last) begin
                    fail = cmp_pkg::ERR_VALUE_TRUNC;
                end
            end
            cmp_pkg::PH_PAYLOAD: begin
                ev = cmp_pkg::EV_PAYLOAD;
                bo = b;
            end
            default: begin
            end
        endcase

        // option length nibble, after the delta is known
        if (run_len) begin
            lnib = work.nibble_pending[3:0];
            work.length_accum = 16'd0;
            if (lnib == NibRsvd) begin
                fail = cmp_pkg::ERR_RESERVED;
            end else if (lnib >= NibExt1) begin
                work.phase = cmp_pkg::PH_LEN_EXT;
                work.hcount = {1'b0, lnib == NibExt2};
                if (last) fail = cmp_pkg::ERR_EXT_TRUNC;
            end else begin
                work.length_accum = {12'd0, lnib};
                run_fin = 1'b1;
            end
        end

        // option header complete
        if (run_fin) begin
            work.running_option = st.running_option + work.delta_accum;
            ostart = 1'b1;
            olen = work.length_accum;
            work.value_left = work.length_accum;
            if (work.length_accum != 16'd0) begin
                work.phase = cmp_pkg::PH_VALUE;
                if (last) fail = cmp_pkg::ERR_VALUE_TRUNC;
            end else begin
                work.phase = cmp_pkg::PH_OPTHDR;
            end
        end

        if (fail != cmp_pkg::ERR_NONE) begin
            work.error_latched = fail;
            if (work.phase != cmp_pkg::PH_HEADER) work.phase = cmp_pkg::PH_DROP;
            ev = cmp_pkg::EV_CONSUMED;
            bo = 8'd0;
            ostart = 1'b0;
            olen = 16'd0;
        end

        hdr_ok = (work.phase != cmp_pkg::PH_HEADER);

        res.event_res     = ev;
        res.byte_out      = bo;
        res.version       = hdr_ok ? work.hdr_byte0[7:6] : 2'd0;
        res.msg_type      = hdr_ok ? work.hdr_byte0[5:4] : 2'd0;
        res.token_length  = hdr_ok ? work.hdr_byte0[3:0] : 4'd0;
        res.code          = hdr_ok ? work.hdr_code : 8'd0;
        res.message_id    = hdr_ok ? {work.id_high, work.id_low} : 16'd0;
        res.option_start  = ostart;
        res.option_number = work.running_option;
        res.option_length = olen;
        res.message_done  = last && (work.error_latched == cmp_pkg::ERR_NONE);
        res.error_code    = work.error_latched;

        // end of datagram starts a fresh header
        nx = work;
        if (last) begin
            nx = '0;
            nx.phase = cmp_pkg::PH_HEADER;
        end
    end

endmodule

`default_nettype wire

[tb/sv/coap_message_parser_test.sv]
// coap_message_parser_test: self-checking testbench for the streaming coap parser
// drives datagrams byte by byte, predicts every result item and compares it in order
// depends on cmp_pkg and coap_message_parser
`timescale 1ns / 100ps

module coap_message_parser_test;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned MAX_GAP        = 17;
    localparam int unsigned REPORT_LIMIT   = 10;

    logic              aclk;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    cmp_pkg::cmp_in_t  s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    cmp_pkg::cmp_out_t m_data;
    logic              cfg_wr_en   = 1'b0;
    logic [3:0]        cfg_wr_data = '0;

    coap_message_parser dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // parser state kept by the predictor
    logic [2:0]  ph;
    logic [1:0]  hdr_idx;
    logic [7:0]  hdr_first;
    logic [7:0]  hdr_code;
    logic [7:0]  id_hi;
    logic [7:0]  id_lo;
    logic [3:0]  token_left;
    logic [15:0] opt_number;
    logic [15:0] delta_sum;
    logic [15:0] length_sum;
    logic [7:0]  opt_header;
    logic [15:0] value_left;
    logic [2:0]  err_latched;
    logic [3:0]  token_limit = cmp_pkg::MAX_TOKEN_RESET;
    logic        opt_start_now;
    logic [15:0] opt_len_now;

    cmp_pkg::cmp_out_t decoded_q[$];
    logic [7:0]        dgram[$];

    bit          calm = 1'b0;
    int unsigned sent_bytes    = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned datagrams     = 0;
    int unsigned clean_dgrams  = 0;
    int unsigned error_dgrams  = 0;
    int unsigned options_seen  = 0;
    int unsigned limit_writes  = 0;
    int unsigned stall_cycles  = 0;

    function automatic void reset_parse_state();
        ph          = cmp_pkg::PH_HEADER;
        hdr_idx     = '0;
        hdr_first   = '0;
        hdr_code    = '0;
        id_hi       = '0;
        id_lo       = '0;
        token_left  = '0;
        opt_number  = '0;
        delta_sum   = '0;
        length_sum  = '0;
        opt_header  = '0;
        value_left  = '0;
        err_latched = cmp_pkg::ERR_NONE;
    endfunction

    initial reset_parse_state();

    function automatic logic [2:0] close_option(input logic last);
        opt_number    = opt_number + delta_sum;
        opt_start_now = 1'b1;
        opt_len_now   = length_sum;
        value_left    = length_sum;
        if (value_left != 0) begin
            ph = cmp_pkg::PH_VALUE;
            if (last) return cmp_pkg::ERR_VALUE_TRUNC;
        end else begin
            ph = cmp_pkg::PH_OPTHDR;
        end
        return cmp_pkg::ERR_NONE;
    endfunction

    function automatic logic [2:0] open_length(input logic last);
        logic [3:0] nib;
        nib        = opt_header[3:0];
        length_sum = '0;
        if (nib == 4'd15) return cmp_pkg::ERR_RESERVED;
        if (nib >= 4'd13) begin
            ph      = cmp_pkg::PH_LEN_EXT;
            hdr_idx = (nib == 4'd14) ? 2'd1 : 2'd0;
            return last ? cmp_pkg::ERR_EXT_TRUNC : cmp_pkg::ERR_NONE;
        end
        length_sum = {12'd0, nib};
        return close_option(last);
    endfunction

    function automatic cmp_pkg::cmp_out_t decode_byte(input cmp_pkg::cmp_in_t item);
        logic [7:0]        b;
        logic              last;
        logic [2:0]        ev;
        logic [7:0]        bo;
        logic [2:0]        fail;
        logic [3:0]        nib;
        logic              hdr_ok;
        cmp_pkg::cmp_out_t r;
        b    = item.data_byte;
        last = item.last_byte;
        ev   = cmp_pkg::EV_CONSUMED;
        bo   = '0;
        fail = cmp_pkg::ERR_NONE;
        opt_start_now = 1'b0;
        opt_len_now   = '0;
        case (ph)
            cmp_pkg::PH_HEADER: begin
                case (hdr_idx)
                    2'd0: hdr_first = b;
                    2'd1: hdr_code = b;
                    2'd2: id_hi = b;
                    default: id_lo = b;
                endcase
                if (hdr_idx != 2'd3) begin
                    hdr_idx = hdr_idx + 2'd1;
                    if (last) fail = cmp_pkg::ERR_SHORT_HEADER;
                end else begin
                    hdr_idx = '0;
                    ev      = cmp_pkg::EV_HEADER;
                    if (hdr_first[3:0] > token_limit) begin
                        ph   = cmp_pkg::PH_DROP;
                        fail = cmp_pkg::ERR_TOKEN_LONG;
                    end else if (hdr_first[3:0] != 0) begin
                        token_left = hdr_first[3:0];
                        ph         = cmp_pkg::PH_TOKEN;
                        if (last) fail = cmp_pkg::ERR_TOKEN_TRUNC;
                    end else begin
                        ph = cmp_pkg::PH_OPTHDR;
                    end
                end
            end
            cmp_pkg::PH_TOKEN: begin
                ev = cmp_pkg::EV_TOKEN;
                bo = b;
                token_left = token_left - 4'd1;
                if (token_left == 0) ph = cmp_pkg::PH_OPTHDR;
                else if (last) fail = cmp_pkg::ERR_TOKEN_TRUNC;
            end
            cmp_pkg::PH_OPTHDR: begin
                if (b == 8'hFF) begin
                    ev = cmp_pkg::EV_MARKER;
                    ph = cmp_pkg::PH_PAYLOAD;
                end else begin
                    nib        = b[7:4];
                    opt_header = b;
                    delta_sum  = '0;
                    length_sum = '0;
                    if (nib == 4'd15) begin
                        fail = cmp_pkg::ERR_RESERVED;
                    end else if (nib >= 4'd13) begin
                        ph      = cmp_pkg::PH_DELTA_EXT;
                        hdr_idx = (nib == 4'd14) ? 2'd1 : 2'd0;
                        if (last) fail = cmp_pkg::ERR_EXT_TRUNC;
                    end else begin
                        delta_sum = {12'd0, nib};
                        fail = open_length(last);
                    end
                end
            end
            cmp_pkg::PH_DELTA_EXT: begin
                delta_sum = {delta_sum[7:0], b};
                if (hdr_idx != 0) begin
                    hdr_idx = '0;
                    if (last) fail = cmp_pkg::ERR_EXT_TRUNC;
                end else begin
                    delta_sum = delta_sum + ((opt_header[7:4] == 4'd13) ? 16'd13 : 16'd269);
                    fail = open_length(last);
                end
            end
            cmp_pkg::PH_LEN_EXT: begin
                length_sum = {length_sum[7:0], b};
                if (hdr_idx != 0) begin
                    hdr_idx = '0;
                    if (last) fail = cmp_pkg::ERR_EXT_TRUNC;
                end else begin
                    length_sum = length_sum + ((opt_header[3:0] == 4'd13) ? 16'd13 : 16'd269);
                    fail = close_option(last);
                end
            end
            cmp_pkg::PH_VALUE: begin
                ev = cmp_pkg::EV_OPT_VALUE;
                bo = b;
                value_left = value_left - 16'd1;
                if (value_left == 0) ph = cmp_pkg::PH_OPTHDR;
                else if (last) fail = cmp_pkg::ERR_VALUE_TRUNC;
            end
            cmp_pkg::PH_PAYLOAD: begin
                ev = cmp_pkg::EV_PAYLOAD;
                bo = b;
            end
            default: begin
            end
        endcase

        // the failing byte reports nothing of its own and the rest is dropped
        if (fail != cmp_pkg::ERR_NONE) begin
            err_latched = fail;
            if (ph != cmp_pkg::PH_HEADER) ph = cmp_pkg::PH_DROP;
            ev = cmp_pkg::EV_CONSUMED;
            bo = '0;
            opt_start_now = 1'b0;
            opt_len_now   = '0;
        end

        hdr_ok          = (ph != cmp_pkg::PH_HEADER);
        r.event_res     = ev;
        r.byte_out      = bo;
        r.version       = hdr_ok ? hdr_first[7:6] : 2'd0;
        r.msg_type      = hdr_ok ? hdr_first[5:4] : 2'd0;
        r.token_length  = hdr_ok ? hdr_first[3:0] : 4'd0;
        r.code          = hdr_ok ? hdr_code : 8'd0;
        r.message_id    = hdr_ok ? {id_hi, id_lo} : 16'd0;
        r.option_start  = opt_start_now;
        r.option_number = opt_number;
        r.option_length = opt_len_now;
        r.message_done  = last && (err_latched == cmp_pkg::ERR_NONE);
        r.error_code    = err_latched;

        if (opt_start_now) options_seen++;
        if (last) begin
            datagrams++;
            if (err_latched == cmp_pkg::ERR_NONE) clean_dgrams++;
            else error_dgrams++;
            reset_parse_state();
        end
        return r;
    endfunction

    function automatic int unsigned draw_gap();
        if (calm) return 0;
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic string fmt_result(input cmp_pkg::cmp_out_t r);
        return $sformatf({"ev=%0d byte=%h ver=%0d type=%0d tkl=%0d code=%h id=%h",
                          " os=%0b on=%h ol=%h done=%0b err=%0d"},
                         r.event_res, r.byte_out, r.version, r.msg_type, r.token_length,
                         r.code, r.message_id, r.option_start, r.option_number,
                         r.option_length, r.message_done, r.error_code);
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic last);
        int unsigned       gap;
        cmp_pkg::cmp_in_t  item;
        cmp_pkg::cmp_out_t predicted;
        gap            = draw_gap();
        item.data_byte = value;
        item.last_byte = last;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = decode_byte(item);
        decoded_q = {decoded_q, predicted};
        sent_bytes++;
    endtask

    task automatic send_datagram();
        for (int i = 0; i < dgram.size(); i++) send_byte(dgram[i], i == dgram.size() - 1);
    endtask

    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_token_limit(input logic [3:0] limit);
        wait_for_drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        token_limit = limit;
        limit_writes++;
    endtask

    function automatic logic [3:0] ext_nibble(input logic [15:0] v);
        if (v < 16'd13) return v[3:0];
        if (v < 16'd269) return 4'd13;
        return 4'd14;
    endfunction

    task automatic add_byte(input logic [7:0] value);
        dgram = {dgram, value};
    endtask

    task automatic push_extension(input logic [15:0] v);
        logic [15:0] rest;
        if (ext_nibble(v) == 4'd13) begin
            rest = v - 16'd13;
            add_byte(rest[7:0]);
        end else if (ext_nibble(v) == 4'd14) begin
            rest = v - 16'd269;
            add_byte(rest[15:8]);
            add_byte(rest[7:0]);
        end
    endtask

    // mostly well-formed datagrams, the rest cut short, corrupted or pure noise
    task automatic build_random_datagram();
        int unsigned tkl;
        int unsigned r;
        int unsigned cut;
        logic [15:0] delta;
        logic [15:0] olen;
        logic [7:0]  first;
        dgram.delete();
        tkl = $urandom_range(0, token_limit);
        if ($urandom_range(0, 3) == 0) tkl = token_limit;
        first      = 8'($urandom);
        first[3:0] = 4'(tkl);
        add_byte(first);
        repeat (3) add_byte(8'($urandom));
        repeat (tkl) add_byte(8'($urandom));
        repeat ($urandom_range(0, 4)) begin
            r = $urandom_range(0, 9);
            if (r < 6) delta = 16'($urandom_range(0, 12));
            else if (r < 9) delta = 16'($urandom_range(13, 268));
            else delta = 16'($urandom_range(269, 65535));
            r = $urandom_range(0, 39);
            if (r < 34) olen = 16'($urandom_range(0, 6));
            else if (r < 39) olen = 16'($urandom_range(13, 24));
            else olen = 16'(269 + $urandom_range(0, 3));
            add_byte({ext_nibble(delta), ext_nibble(olen)});
            push_extension(delta);
            push_extension(olen);
            repeat (olen) add_byte(8'($urandom));
        end
        if ($urandom_range(0, 1) == 1) begin
            add_byte(8'hFF);
            repeat ($urandom_range(0, 8)) add_byte(8'($urandom));
        end
        case ($urandom_range(0, 9))
            0: begin
                if (dgram.size() > 1) begin
                    cut   = $urandom_range(1, dgram.size() - 1);
                    dgram = dgram[0:cut-1];
                end
            end
            1: dgram[$urandom_range(0, dgram.size() - 1)] = 8'($urandom);
            2: begin
                dgram.delete();
                repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
            end
            3: begin
                if (token_limit != 4'd15) begin
                    first      = dgram[0];
                    first[3:0] = 4'($urandom_range(token_limit + 1, 15));
                    dgram[0]   = first;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic test_header_edges();
        // empty payload after the marker on the last byte
        dgram = '{8'hC0, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_datagram();
        dgram = '{8'h01, 8'h45, 8'h12};
        send_datagram();
    endtask

    task automatic test_token_limit();
        // token length above the reset limit, then a dropped byte
        dgram = '{8'h0D, 8'hFF, 8'hFF, 8'hFF, 8'h55};
        send_datagram();
    endtask

    task automatic test_reserved_nibbles();
        // extended delta followed by reserved length
        dgram = '{8'h40, 8'h01, 8'hAB, 8'hCD, 8'hDF, 8'h02};
        send_datagram();
        // two-byte delta extension cut short
        dgram = '{8'h40, 8'h00, 8'h00, 8'h01, 8'hEF, 8'h01};
        send_datagram();
        dgram = '{8'h60, 8'h00, 8'h00, 8'h00, 8'hF0};
        send_datagram();
    endtask

    task automatic test_random_traffic(input int unsigned budget);
        int unsigned start;
        start = sent_bytes;
        while (sent_bytes - start < budget) begin
            build_random_datagram();
            send_datagram();
        end
    endtask

    task automatic test_limit_extremes();
        set_token_limit(4'd0);
        test_random_traffic(200);
        set_token_limit(4'd15);
        test_random_traffic(400);
        set_token_limit(4'($urandom_range(0, 15)));
        test_random_traffic(250);
    endtask

    task automatic test_steady_stream();
        calm = 1'b1;
        set_token_limit(4'd8);
        test_random_traffic(300);
        calm = 1'b0;
    endtask

    task automatic test_drain_pause();
        test_random_traffic(200);
        wait_for_drain();
        test_random_traffic(200);
    endtask

    initial begin : result_sink
        int unsigned gap;
        forever begin
            gap = draw_gap();
            @(negedge aclk);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : result_check
        cmp_pkg::cmp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (decoded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result item: %s", fmt_result(m_data));
            end else begin
                want = decoded_q.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("mismatch on result item %0d", results_seen);
                        $display("  expected %s", fmt_result(want));
                        $display("  actual   %s", fmt_result(m_data));
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("timeout with %0d result items outstanding", decoded_q.size());
        $display("FAIL");
        $finish;
    end

    initial begin : test_sequence
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_header_edges();
        test_token_limit();
        test_reserved_nibbles();
        test_random_traffic(400);
        test_limit_extremes();
        test_steady_stream();
        test_drain_pause();
        wait_for_drain();

        $display("ran %0d bytes in %0d datagrams: %0d parsed clean, %0d with errors",
                 sent_bytes, datagrams, clean_dgrams, error_dgrams);
        $display("decoded %0d options across %0d token limit settings, %0d mismatches",
                 options_seen, limit_writes + 1, mismatches);
        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
